/* rtl/edf_pkg.sv */
// Shared types and constants for the EDF tick scheduler.
`default_nettype none
package edf_pkg;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] bud;
        logic [15:0] per;
        logic [31:0] dl;
    } t_entry;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic REG_ACTIVE  = 1'b0;
    localparam logic REG_RUN_LEN = 1'b1;

    localparam logic [3:0]  ACTIVE_RST  = 4'd8;
    localparam logic [31:0] RUN_LEN_RST = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

/* rtl/edf_task_mem.sv */
// Task table memory with per-entry valid bits and registered read.
`default_nettype none
module edf_task_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_wr_en,
    input  wire                  i_set_vld,
    input  wire [AW-1:0]         i_wr_addr,
    input  edf_pkg::t_entry      i_wr_data,
    input  wire [AW-1:0]         i_rd_addr,
    output edf_pkg::t_entry      o_rd_data,
    output logic                 o_rd_vld
);
    import edf_pkg::*;

    t_entry           r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_entry           r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en && i_set_vld) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

endmodule
`default_nettype wire

/* rtl/edf_tick_scheduler.sv */
// Earliest-deadline-first tick scheduler, top level.
// Load beat: taken while idle, no result, busy stays low.
// Tick beat: busy while the first n entries (n = live entries) of the table
// memory are scanned, one per cycle through a single subtract/compare, and
// during an update state; the result strobe is registered from that state and follows in the cycle after it.
// Synchronous active-low reset: time zero, all entries not ready, defaults.
`default_nettype none
module edf_tick_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_req_type,
    input  wire  [2:0]  i_task_slot,
    input  wire  [15:0] i_exec_time,
    input  wire  [31:0] i_first_deadline,
    input  wire  [15:0] i_period,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_idx,
    input  wire  [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_ran,
    output logic [2:0]  o_run_slot,
    output logic [31:0] o_run_deadline,
    output logic        o_completed,
    output logic [31:0] o_tick_time
);
    import edf_pkg::*;

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [3:0]    r_active;
    logic [31:0]   r_run_len;
    logic [31:0]   r_now, n_now;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_found, n_found;
    logic [AW-1:0] r_best, n_best;
    t_entry        r_bent, n_bent;

    logic          r_strobe, n_strobe;
    logic          r_ran, n_ran;
    logic [2:0]    r_slot, n_slot;
    logic [31:0]   r_dl, n_dl;
    logic          r_done, n_done;
    logic [31:0]   r_time, n_time;

    logic          acc, acc_load, acc_tick;
    logic [CW-1:0] live;
    logic          wr_en, set_vld;
    logic [AW-1:0] wr_addr, rd_addr;
    t_entry        wr_data, rd_data;
    logic          rd_vld;
    logic [31:0]   diff;
    logic [15:0]   rem_dec;
    logic          fin;

    edf_task_mem #(.DEPTH(MAX_TASKS), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_set_vld (set_vld),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_rd_vld  (rd_vld)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign acc         = start && !busy;
    assign acc_load    = acc && (i_req_type == REQ_LOAD)
                         && (32'(i_task_slot) < 32'(MAX_TASKS));
    assign acc_tick    = acc && (i_req_type == REQ_TICK) && (r_now < r_run_len);
    assign live        = (32'(r_active) > 32'(MAX_TASKS)) ? CW'(MAX_TASKS)
                                                          : CW'(r_active);

    assign diff    = rd_data.dl - r_bent.dl;
    assign rem_dec = r_bent.rem - 16'd1;
    assign fin     = (rem_dec == 16'd0);

    always_comb begin
        n_state  = r_state;
        n_now    = r_now;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_found  = r_found;
        n_best   = r_best;
        n_bent   = r_bent;
        n_strobe = 1'b0;
        n_ran    = r_ran;
        n_slot   = r_slot;
        n_dl     = r_dl;
        n_done   = r_done;
        n_time   = r_time;
        wr_en    = 1'b0;
        set_vld  = 1'b0;
        wr_addr  = AW'(i_task_slot);
        wr_data.rem = i_exec_time;
        wr_data.bud = i_exec_time;
        wr_data.per = i_period;
        wr_data.dl  = i_first_deadline;
        rd_addr  = '0;
        case (r_state)
            ST_IDLE: begin
                if (acc_load) begin
                    wr_en   = 1'b1;
                    set_vld = 1'b1;
                end
                if (acc_tick) begin
                    n_idx   = '0;
                    n_cnt   = live;
                    n_found = 1'b0;
                    n_best  = '0;
                    n_state = (live == '0) ? ST_UPD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_addr = AW'(r_idx + 1'b1);
                if (rd_vld && (rd_data.rem != 16'd0) && (!r_found || diff[31])) begin
                    n_found = 1'b1;
                    n_best  = r_idx;
                    n_bent  = rd_data;
                end
                n_idx = AW'(r_idx + 1'b1);
                if ((CW'(r_idx) + 1'b1) == r_cnt) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_strobe = 1'b1;
                n_time   = r_now;
                n_now    = r_now + 32'd1;
                n_ran    = r_found;
                n_slot   = r_found ? 3'(r_best) : 3'd0;
                n_dl     = r_found ? r_bent.dl : 32'd0;
                n_done   = r_found && fin;
                wr_en    = r_found;
                wr_addr  = r_best;
                wr_data.bud = r_bent.bud;
                wr_data.per = r_bent.per;
                wr_data.rem = fin ? r_bent.bud : rem_dec;
                wr_data.dl  = fin ? (r_bent.dl + 32'(r_bent.per)) : r_bent.dl;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_active  <= ACTIVE_RST;
            r_run_len <= RUN_LEN_RST;
            r_now     <= '0;
            r_strobe  <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_strobe <= n_strobe;
            r_found  <= n_found;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_idx)
                    REG_ACTIVE:  r_active  <= i_cfg_data[3:0];
                    REG_RUN_LEN: r_run_len <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_best <= n_best;
        r_bent <= n_bent;
        r_ran  <= n_ran;
        r_slot <= n_slot;
        r_dl   <= n_dl;
        r_done <= n_done;
        r_time <= n_time;
    end

    assign o_strobe       = r_strobe;
    assign o_ran          = r_ran;
    assign o_run_slot     = r_slot;
    assign o_run_deadline = r_dl;
    assign o_completed    = r_done;
    assign o_tick_time    = r_time;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy) else $error("strobe while busy");

    a_upd_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |=> o_strobe) else $error("update without result");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_tick |=> busy) else $error("tick not taken");

    a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_tick_time == r_now - 32'd1)) else $error("time mismatch");

    a_done_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_completed) |-> o_ran) else $error("completion when idle");

endmodule
`default_nettype wire
